// ===== src/rc4_pkg.sv =====
// Shared types, constants and the microcode table of the RC4 engine.
package rc4_pkg;

    localparam int BYTE_W            = 8;
    localparam int PERM_SIZE         = 256;
    localparam int MAX_KEY_BYTES_DEF = 256;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_INIT_END,
        ST_K0,
        ST_K1,
        ST_K2,
        ST_K3,
        ST_KS_END,
        ST_D1,
        ST_D2,
        ST_D3
    } step_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_INEXT,
        RD_K,
        RD_JSUM,
        RD_T
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_IDENT,
        WR_K_RD,
        WR_I_RD,
        WR_J_SI
    } wr_sel_t;

    typedef enum logic [2:0] {
        JC_NEXT,
        JC_DISPATCH,
        JC_K_MORE,
        JC_SCHED
    } jump_t;

    typedef struct packed {
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        logic    ld_si;
        logic    ld_j;
        logic    ld_sj;
        logic    add_key;
        logic    k_inc;
        logic    kidx_inc;
        logic    clr_ij;
        logic    emit;
        jump_t   jc;
        step_t   nxt;
        step_t   tgt;
    } ctrl_t;

    typedef struct packed {
        logic acc_data;
        logic acc_key_last;
        logic k_last;
        logic sched;
        logic out_busy;
    } seq_stat_t;

    // Microcode ROM: one control word per step.
    function automatic ctrl_t ucode(step_t s);
        ctrl_t c;
        c = '{rd_sel: RD_NONE, wr_sel: WR_NONE, ld_si: 1'b0, ld_j: 1'b0, ld_sj: 1'b0,
              add_key: 1'b0, k_inc: 1'b0, kidx_inc: 1'b0, clr_ij: 1'b0, emit: 1'b0,
              jc: JC_NEXT, nxt: ST_IDLE, tgt: ST_IDLE};
        unique case (s)
            ST_IDLE: begin
                c.rd_sel = RD_INEXT;
                c.jc     = JC_DISPATCH;
            end
            ST_INIT: begin
                c.wr_sel = WR_IDENT;
                c.k_inc  = 1'b1;
                c.jc     = JC_K_MORE;
                c.tgt    = ST_INIT;
                c.nxt    = ST_INIT_END;
            end
            ST_INIT_END: begin
                c.jc  = JC_SCHED;
                c.nxt = ST_K0;
                c.tgt = ST_IDLE;
            end
            ST_K0: begin
                c.rd_sel = RD_K;
                c.nxt    = ST_K1;
            end
            ST_K1: begin
                c.rd_sel  = RD_JSUM;
                c.ld_si   = 1'b1;
                c.ld_j    = 1'b1;
                c.add_key = 1'b1;
                c.nxt     = ST_K2;
            end
            ST_K2: begin
                c.wr_sel = WR_K_RD;
                c.nxt    = ST_K3;
            end
            ST_K3: begin
                c.wr_sel   = WR_J_SI;
                c.k_inc    = 1'b1;
                c.kidx_inc = 1'b1;
                c.jc       = JC_K_MORE;
                c.tgt      = ST_K0;
                c.nxt      = ST_KS_END;
            end
            ST_KS_END: begin
                c.clr_ij = 1'b1;
                c.nxt    = ST_IDLE;
            end
            ST_D1: begin
                c.rd_sel = RD_JSUM;
                c.ld_si  = 1'b1;
                c.ld_j   = 1'b1;
                c.nxt    = ST_D2;
            end
            ST_D2: begin
                c.rd_sel = RD_T;
                c.wr_sel = WR_I_RD;
                c.ld_sj  = 1'b1;
                c.nxt    = ST_D3;
            end
            ST_D3: begin
                c.wr_sel = WR_J_SI;
                c.emit   = 1'b1;
                c.nxt    = ST_IDLE;
            end
            default: begin
                c.nxt = ST_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

// ===== src/rc4_seq.sv =====
// Microcode sequencer: step register, control ROM and jump logic.
module rc4_seq
    import rc4_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  seq_stat_t stat,
    output ctrl_t     ctrl,
    output step_t     step
);

    step_t step_reg;
    step_t step_next;

    always_comb begin
        ctrl = ucode(step_reg);
    end

    always_comb begin
        step_next = step_reg;
        if (!(ctrl.emit && stat.out_busy)) begin
            unique case (ctrl.jc)
                JC_NEXT:     step_next = ctrl.nxt;
                JC_DISPATCH: begin
                    if (stat.acc_data) begin
                        step_next = ST_D1;
                    end else if (stat.acc_key_last) begin
                        step_next = ST_INIT;
                    end else begin
                        step_next = ST_IDLE;
                    end
                end
                JC_K_MORE:   step_next = stat.k_last ? ctrl.nxt : ctrl.tgt;
                JC_SCHED:    step_next = stat.sched ? ctrl.nxt : ctrl.tgt;
                default:     step_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_INIT;
        end else begin
            step_reg <= step_next;
        end
    end

    assign step = step_reg;

endmodule

// ===== src/rc4_stream_cipher.sv =====
// RC4 engine top level: key store, permutation memory and datapath.
//
//   channel  dir  ports                              meaning
//   s_       in   s_valid s_ready s_func s_in_byte   key byte or data byte request
//                 s_last
//   m_       out  m_valid m_ready m_out_byte         data byte XOR keystream
//                 m_out_last
//
// A data byte takes the accept step plus three microcode steps; the single
// read port of the permutation memory sets this sequence.
// A final key byte starts an identity fill of all 256 entries, then a key
// schedule (4 steps per entry), INIT_END and KS_END; s_ready is low meanwhile.
// After reset a full identity fill runs before the first request is taken.
// A result held by m_ready low stalls the last data step; the output register
// lets the next request be accepted while a result waits.
module rc4_stream_cipher
    import rc4_pkg::*;
#(
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_func,
    input  logic [BYTE_W-1:0] s_in_byte,
    input  logic              s_last,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_out_byte,
    output logic              m_out_last
);

    localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int CNT_W  = $clog2(MAX_KEY_BYTES + 1);

    ctrl_t     ctrl;
    step_t     step;
    seq_stat_t stat;

    logic [BYTE_W-1:0] perm_mem [PERM_SIZE];
    logic [BYTE_W-1:0] key_mem  [MAX_KEY_BYTES];

    logic [BYTE_W-1:0] perm_rdata_reg;
    logic [BYTE_W-1:0] key_rdata_reg;

    logic [BYTE_W-1:0] i_reg, i_next;
    logic [BYTE_W-1:0] j_reg, j_next;
    logic [BYTE_W-1:0] k_reg, k_next;
    logic [KIDX_W-1:0] kidx_reg, kidx_next;
    logic [CNT_W-1:0]  key_count_reg, key_count_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic              sched_reg, sched_next;
    logic              m_valid_reg, m_valid_next;

    logic [BYTE_W-1:0] si_reg, sj_reg, t_reg;
    logic [BYTE_W-1:0] data_reg;
    logic              last_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;

    logic              s_accept;
    logic              key_room;
    logic              key_wr;
    logic [BYTE_W-1:0] jsum;
    logic [BYTE_W-1:0] tsum;
    logic [BYTE_W-1:0] raddr;
    logic              rd_en;
    logic [BYTE_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              we;
    logic [BYTE_W-1:0] ks;
    logic              emit_go;
    logic [CNT_W-1:0]  kidx_inc;

    assign s_ready  = (step == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign key_room = (key_count_reg < CNT_W'(MAX_KEY_BYTES));
    assign key_wr   = s_accept && !s_func && key_room;
    assign emit_go  = ctrl.emit && (!m_valid_reg || m_ready);

    assign stat.acc_data     = s_accept && s_func;
    assign stat.acc_key_last = s_accept && !s_func && s_last;
    assign stat.k_last       = (k_reg == 8'hFF);
    assign stat.sched        = sched_reg;
    assign stat.out_busy     = m_valid_reg && !m_ready;

    rc4_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl),
        .step    (step)
    );

    assign jsum     = j_reg + perm_rdata_reg + (ctrl.add_key ? key_rdata_reg : 8'd0);
    assign tsum     = si_reg + perm_rdata_reg;
    assign kidx_inc = CNT_W'(kidx_reg) + CNT_W'(1);

    always_comb begin
        raddr = '0;
        rd_en = 1'b1;
        case (ctrl.rd_sel)
            RD_INEXT: raddr = i_reg + 8'd1;
            RD_K:     raddr = k_reg;
            RD_JSUM:  raddr = jsum;
            RD_T:     raddr = tsum;
            default:  rd_en = 1'b0;
        endcase
    end

    always_comb begin
        waddr = '0;
        wdata = '0;
        we    = 1'b1;
        case (ctrl.wr_sel)
            WR_IDENT: begin
                waddr = k_reg;
                wdata = k_reg;
            end
            WR_K_RD: begin
                waddr = k_reg;
                wdata = perm_rdata_reg;
            end
            WR_I_RD: begin
                waddr = i_reg;
                wdata = perm_rdata_reg;
            end
            WR_J_SI: begin
                waddr = j_reg;
                wdata = si_reg;
            end
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            perm_mem[waddr] <= wdata;
        end
        if (rd_en) begin
            perm_rdata_reg <= perm_mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (key_wr) begin
            key_mem[key_count_reg[KIDX_W-1:0]] <= s_in_byte;
        end
        if (ctrl.rd_sel == RD_K) begin
            key_rdata_reg <= key_mem[kidx_reg];
        end
    end

    // Swap already written for i; t hitting i or j must see the swapped values.
    always_comb begin
        if (t_reg == j_reg) begin
            ks = si_reg;
        end else if (t_reg == i_reg) begin
            ks = sj_reg;
        end else begin
            ks = perm_rdata_reg;
        end
    end

    always_comb begin
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        kidx_next      = kidx_reg;
        key_count_next = key_count_reg;
        len_next       = len_reg;
        sched_next     = sched_reg;
        m_valid_next   = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (emit_go) begin
            m_valid_next = 1'b1;
        end
        if (ctrl.ld_j) begin
            j_next = jsum;
        end
        if (ctrl.k_inc) begin
            k_next = k_reg + 8'd1;
        end
        if (ctrl.kidx_inc) begin
            kidx_next = (kidx_inc >= len_reg) ? '0 : kidx_inc[KIDX_W-1:0];
        end
        if (ctrl.clr_ij) begin
            i_next     = '0;
            j_next     = '0;
            sched_next = 1'b0;
        end

        if (stat.acc_data) begin
            i_next = i_reg + 8'd1;
        end
        if (key_wr) begin
            key_count_next = key_count_reg + CNT_W'(1);
        end
        if (stat.acc_key_last) begin
            len_next       = key_room ? key_count_reg + CNT_W'(1) : key_count_reg;
            key_count_next = '0;
            sched_next     = 1'b1;
            i_next         = '0;
            j_next         = '0;
            k_next         = '0;
            kidx_next      = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            kidx_reg      <= '0;
            key_count_reg <= '0;
            len_reg       <= CNT_W'(1);
            sched_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            kidx_reg      <= kidx_next;
            key_count_reg <= key_count_next;
            len_reg       <= len_next;
            sched_reg     <= sched_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            data_reg <= s_in_byte;
            last_reg <= s_last;
        end
        if (ctrl.ld_si) begin
            si_reg <= perm_rdata_reg;
        end
        if (ctrl.ld_sj) begin
            sj_reg <= perm_rdata_reg;
            t_reg  <= tsum;
        end
        if (emit_go) begin
            out_byte_reg <= data_reg ^ ks;
            out_last_reg <= last_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_out_last = out_last_reg;

    a_rise_from_d3: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg ##1 m_valid_reg |-> $past(step == ST_D3))
        else $error("result appeared outside the final data step");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        key_count_reg <= CNT_W'(MAX_KEY_BYTES))
        else $error("key count beyond store depth");

    a_data_start: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.acc_data |=> step == ST_D1)
        else $error("data request did not start the data steps");

    a_len_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        step == ST_K0 |-> (len_reg != '0) && (CNT_W'(kidx_reg) < len_reg))
        else $error("key index outside key length");

    a_init_end: assert property (@(posedge aclk) disable iff (!aresetn)
        step == ST_INIT && k_reg == 8'hFF |=> step == ST_INIT_END && k_reg == 8'd0)
        else $error("identity fill did not end cleanly");

endmodule

// ===== tb/sv/rc4_stream_cipher_tb.sv =====
// Self-checking testbench for the RC4 engine: random key/data requests against a keystream predictor.
`timescale 1ns / 100ps

module rc4_stream_cipher_tb;
    import rc4_pkg::*;

    localparam logic FUNC_KEY    = 1'b0;
    localparam logic FUNC_DATA   = 1'b1;
    localparam int   RANDOM_REQS = 750;
    localparam int   IDLE_LIMIT  = 5000;
    // full identity fill plus key schedule, with margin
    localparam int   SETTLE_CYCLES = 1400;

    typedef struct {
        logic              func;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              drain;   // hold until all results are back
    } cipher_req_t;

    typedef struct {
        logic [BYTE_W-1:0] text;
        logic              flag;
    } cipher_out_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    logic              s_func    = FUNC_KEY;
    logic [BYTE_W-1:0] s_in_byte = '0;
    logic              s_last    = 1'b0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    logic [BYTE_W-1:0] m_out_byte;
    logic              m_out_last;

    cipher_req_t pending_reqs[$];
    cipher_out_t expected_bytes[$];
    cipher_req_t cur_req;
    int          total_reqs  = 0;
    int          sent_reqs   = 0;
    int          mismatches  = 0;
    int          idle_cycles = 0;
    int          burst_left  = 0;
    int          gap_left    = 0;
    int          rx_cyc      = 0;
    int          rx_mode     = 0;

    // predictor state
    logic [BYTE_W-1:0] sbox[PERM_SIZE];
    logic [BYTE_W-1:0] key_buf[PERM_SIZE];
    int                key_len;
    logic [BYTE_W-1:0] ks_i;
    logic [BYTE_W-1:0] ks_j;

    rc4_stream_cipher dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_func),
        .s_in_byte (s_in_byte),
        .s_last    (s_last),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_byte(m_out_byte),
        .m_out_last(m_out_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic run_key_schedule(input int len);
        logic [BYTE_W-1:0] jj;
        logic [BYTE_W-1:0] t;
        int                kidx;
        jj   = '0;
        kidx = 0;
        for (int k = 0; k < PERM_SIZE; k++) sbox[k] = 8'(k);
        for (int k = 0; k < PERM_SIZE; k++) begin
            jj      = jj + sbox[k] + key_buf[kidx];
            t       = sbox[k];
            sbox[k] = sbox[jj];
            sbox[jj] = t;
            kidx++;
            if (kidx >= len) kidx = 0;
        end
        ks_i = '0;
        ks_j = '0;
    endtask

    task automatic apply_request(input cipher_req_t r);
        logic [BYTE_W-1:0] t;
        logic [BYTE_W-1:0] sum;
        cipher_out_t       res;
        if (r.func == FUNC_KEY) begin
            // key bytes past the store size are dropped, count saturates
            if (key_len < MAX_KEY_BYTES_DEF) begin
                key_buf[key_len] = r.data;
                key_len++;
            end
            if (r.last) begin
                run_key_schedule(key_len == 0 ? 1 : key_len);
                key_len = 0;
            end
        end else begin
            ks_i       = ks_i + 8'd1;
            ks_j       = ks_j + sbox[ks_i];
            t          = sbox[ks_i];
            sbox[ks_i] = sbox[ks_j];
            sbox[ks_j] = t;
            sum        = sbox[ks_i] + sbox[ks_j];
            res.text   = r.data ^ sbox[sum];
            res.flag   = r.last;
            expected_bytes.push_back(res);
        end
    endtask

    task automatic push_req(input logic func, input logic [BYTE_W-1:0] data,
                            input logic last, input logic drain);
        cipher_req_t r;
        r.func  = func;
        r.data  = data;
        r.last  = last;
        r.drain = drain;
        pending_reqs.push_back(r);
        total_reqs++;
    endtask

    task automatic push_data_run(input int n);
        logic lst;
        for (int k = 0; k < n; k++) begin
            lst = (k == n - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0);
            push_req(FUNC_DATA, 8'($urandom), lst, 1'b0);
        end
    endtask

    // n key bytes, last on the final one; data may be mixed in between
    task automatic push_key(input int n, input bit mix_data);
        for (int k = 0; k < n; k++) begin
            push_req(FUNC_KEY, 8'($urandom), k == n - 1, 1'b0);
            if (mix_data && k != n - 1 && $urandom_range(0, 2) == 0)
                push_data_run($urandom_range(1, 3));
        end
    endtask

    task automatic flag_error(input string msg);
        if (mismatches < 10) $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // stimulus
    initial begin : stim
        int seq_no;
        int pick;
        int n;
        for (int k = 0; k < PERM_SIZE; k++) begin
            sbox[k]    = 8'(k);
            key_buf[k] = '0;
        end
        key_len = 0;
        ks_i    = '0;
        ks_j    = '0;

        // data before any key runs on the identity permutation
        push_req(FUNC_DATA, 8'h00, 1'b0, 1'b0);
        push_req(FUNC_DATA, 8'hFF, 1'b1, 1'b0);
        push_req(FUNC_DATA, 8'hA5, 1'b0, 1'b0);
        // single-byte keys at both extremes
        push_req(FUNC_KEY,  8'h00, 1'b1, 1'b0);
        push_req(FUNC_DATA, 8'hFF, 1'b0, 1'b1);
        push_req(FUNC_DATA, 8'h00, 1'b1, 1'b0);
        push_req(FUNC_KEY,  8'hFF, 1'b1, 1'b0);
        push_req(FUNC_DATA, 8'h3C, 1'b0, 1'b0);
        push_req(FUNC_DATA, 8'hC3, 1'b1, 1'b0);
        // data between key bytes uses the current permutation
        push_req(FUNC_KEY,  8'hFF, 1'b0, 1'b0);
        push_req(FUNC_KEY,  8'h01, 1'b0, 1'b0);
        push_req(FUNC_DATA, 8'h5A, 1'b0, 1'b0);
        push_req(FUNC_KEY,  8'h80, 1'b0, 1'b0);
        push_req(FUNC_DATA, 8'hA5, 1'b1, 1'b0);
        push_req(FUNC_KEY,  8'h7F, 1'b1, 1'b0);
        push_req(FUNC_DATA, 8'h00, 1'b0, 1'b0);
        push_req(FUNC_DATA, 8'hFF, 1'b0, 1'b0);
        push_req(FUNC_DATA, 8'h81, 1'b1, 1'b0);

        seq_no = 0;
        while (total_reqs < 18 + RANDOM_REQS) begin
            pick = $urandom_range(0, 99);
            if (seq_no == 2) begin
                // key fills the store exactly
                push_key(MAX_KEY_BYTES_DEF, 1'b0);
                push_data_run($urandom_range(4, 12));
            end else if (seq_no == 6) begin
                // overlong key: extra bytes and the final one are dropped
                push_key(MAX_KEY_BYTES_DEF + $urandom_range(1, 4), 1'b0);
                push_data_run($urandom_range(4, 12));
            end else if (seq_no == 10) begin
                push_req(FUNC_DATA, 8'($urandom), 1'b1, 1'b1);
            end else if (pick < 55) begin
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
                push_key(n, 1'b0);
                push_data_run($urandom_range(1, 40));
            end else if (pick < 70) begin
                push_data_run($urandom_range(1, 30));
            end else if (pick < 82) begin
                push_key($urandom_range(2, 10), 1'b1);
                push_data_run($urandom_range(1, 20));
            end else begin
                // noise, including key bytes with no closing last
                n = $urandom_range(1, 10);
                for (int k = 0; k < n; k++)
                    push_req(1'($urandom), 8'($urandom), 1'($urandom), 1'b0);
            end
            seq_no++;
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (sent_reqs < total_reqs) @(posedge aclk);
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // request driver: bursts with random gaps
    always @(posedge aclk) begin : drv
        logic nxt_valid;
        nxt_valid = s_valid;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_request(cur_req);
                sent_reqs++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_reqs.size() > 0 &&
                             !(pending_reqs[0].drain && expected_bytes.size() > 0)) begin
                    cur_req   = pending_reqs.pop_front();
                    nxt_valid = 1'b1;
                    s_func    <= cur_req.func;
                    s_in_byte <= cur_req.data;
                    s_last    <= cur_req.last;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        if ($urandom_range(0, 3) == 0)
                            gap_left = 0;
                        else
                            gap_left = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 40 : 5);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
        s_valid <= nxt_valid;
    end

    // result backpressure in one of four randomly picked modes
    always @(posedge aclk) begin : rx_stall
        logic rdy;
        rdy = 1'b0;
        if (aresetn) begin
            if (rx_cyc % 128 == 0) rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0: begin
                    rdy = 1'b1;
                end
                1: begin
                    rdy = 1'($urandom);
                end
                2: begin
                    rdy = ($urandom_range(0, 4) == 0);
                end
                default: begin
                    rdy = (rx_cyc % 48) >= 40;
                end
            endcase
            rx_cyc++;
        end
        m_ready <= rdy;
    end

    always @(posedge aclk) begin : mon
        cipher_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                flag_error($sformatf("unexpected result byte=%02h last=%0b",
                                     m_out_byte, m_out_last));
            end else begin
                want = expected_bytes.pop_front();
                if (m_out_byte !== want.text || m_out_last !== want.flag)
                    flag_error($sformatf("byte exp %02h got %02h, last exp %0b got %0b",
                                         want.text, m_out_byte, want.flag, m_out_last));
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule
